### rtl/fll_pkg.sv
// Shared types, codes and defaults for the FIFO lock with lease timeout.
package fll_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int LEASE_BITS_DEF  = 32;
  localparam int CLIENT_W        = 64;
  localparam int LEASE_IN_W      = 32;

  // Command codes of an input item
  typedef enum logic [1:0] {
    KIND_LOCK   = 2'd0,
    KIND_UNLOCK = 2'd1,
    KIND_DISC   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  // Result kinds
  typedef enum logic {
    RK_ANSWER = 1'b0,
    RK_GRANT  = 1'b1
  } rkind_t;

  // Answer codes
  typedef enum logic [1:0] {
    ANS_REFUSED = 2'd0,
    ANS_OK      = 2'd1,
    ANS_FULL    = 2'd2
  } answer_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_GRANT_RD,
    ST_GRANT,
    ST_RESP
  } state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CLIENT_W-1:0]   client_id;
    logic [LEASE_IN_W-1:0] lease_ms;
  } in_item_t;

  typedef struct packed {
    rkind_t              result_kind;
    logic [CLIENT_W-1:0] target_client;
    answer_t             answer;
    logic                last_in_run;
  } out_item_t;

endpackage

### rtl/fll_queue_mem.sv
// Wait queue storage: one write port, one read port, registered read data.
module fll_queue_mem #(
  parameter int QUEUE_DEPTH = fll_pkg::QUEUE_DEPTH_DEF,
  parameter int LEASE_BITS  = fll_pkg::LEASE_BITS_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fll_pkg::CLIENT_W-1:0]  wclient,
  input  logic [LEASE_BITS-1:0]         wlease,
  input  logic [AW-1:0]                 raddr,
  output logic [fll_pkg::CLIENT_W-1:0]  rclient,
  output logic [LEASE_BITS-1:0]         rlease
);

  logic [fll_pkg::CLIENT_W-1:0] client_mem [QUEUE_DEPTH];
  logic [LEASE_BITS-1:0]        lease_mem  [QUEUE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      client_mem[waddr] <= wclient;
      lease_mem[waddr]  <= wlease;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rclient <= client_mem[raddr];
    rlease  <= lease_mem[raddr];
  end

endmodule

### rtl/fll_out_reg.sv
// Output register between the controller and the result channel.
module fll_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fll_pkg::out_item_t push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fll_pkg::out_item_t out_data
);

  logic               valid_r, valid_nxt;
  fll_pkg::out_item_t data_r;

  assign push_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push_valid && push_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload holds until replaced by a new transfer
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_data;
    end
  end

endmodule

### rtl/fll_ctrl.sv
// Lock controller: owner and lease registers, queue pointers, command sequencer.
module fll_ctrl #(
  parameter int QUEUE_DEPTH = fll_pkg::QUEUE_DEPTH_DEF,
  parameter int LEASE_BITS  = fll_pkg::LEASE_BITS_DEF,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fll_pkg::in_item_t             in_data,
  output logic                          push_valid,
  input  logic                          push_ready,
  output fll_pkg::out_item_t            push_data,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [fll_pkg::CLIENT_W-1:0]  mem_wclient,
  output logic [LEASE_BITS-1:0]         mem_wlease,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [fll_pkg::CLIENT_W-1:0]  mem_rclient,
  input  logic [LEASE_BITS-1:0]         mem_rlease
);

  fll_pkg::state_t              state_r, state_nxt;
  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [LEASE_BITS-1:0]        rem_r, rem_nxt;
  logic [fll_pkg::CLIENT_W-1:0] owner_r, owner_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic [fll_pkg::CLIENT_W-1:0] cli_r, cli_nxt;
  fll_pkg::out_item_t           pend_r, pend_nxt;
  logic                         serve_r, serve_nxt;
  logic [AW-1:0]                rd_off, wr_off;
  logic [LEASE_BITS-1:0]        lease_sat;
  logic [AW-1:0]                head_inc;
  logic                         idx_is_last;

  // Queue position relative to the head, wrapping at the depth
  function automatic logic [AW-1:0] qpos(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Requested lease, saturated to the lease counter width
  always_comb begin
    lease_sat = LEASE_BITS'(in_data.lease_ms);
    if (LEASE_BITS < fll_pkg::LEASE_IN_W &&
        (in_data.lease_ms >> LEASE_BITS) != '0) begin
      lease_sat = '1;
    end
  end

  assign head_inc    = qpos(head_r, AW'(1));
  assign idx_is_last = (CW'(idx_r) == count_r - CW'(1));
  assign mem_raddr   = qpos(head_r, rd_off);
  assign mem_waddr   = qpos(head_r, wr_off);
  assign push_data   = pend_r;

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    owner_nxt   = owner_r;
    idx_nxt     = idx_r;
    cli_nxt     = cli_r;
    pend_nxt    = pend_r;
    serve_nxt   = serve_r;
    in_ready    = 1'b0;
    push_valid  = 1'b0;
    mem_we      = 1'b0;
    wr_off      = '0;
    rd_off      = '0;
    mem_wclient = cli_r;
    mem_wlease  = lease_sat;

    unique case (state_r)
      fll_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cli_nxt                = in_data.client_id;
          serve_nxt              = 1'b0;
          pend_nxt.result_kind   = fll_pkg::RK_ANSWER;
          pend_nxt.target_client = in_data.client_id;
          pend_nxt.answer        = fll_pkg::ANS_REFUSED;
          pend_nxt.last_in_run   = 1'b1;
          unique case (in_data.kind)
            fll_pkg::KIND_LOCK: begin
              if (count_r == '0) begin
                // free lock: take it at once
                mem_we          = 1'b1;
                mem_wclient     = in_data.client_id;
                owner_nxt       = in_data.client_id;
                rem_nxt         = lease_sat;
                count_nxt       = CW'(1);
                pend_nxt.answer = fll_pkg::ANS_OK;
                state_nxt       = fll_pkg::ST_RESP;
              end else if (owner_r == in_data.client_id) begin
                state_nxt = fll_pkg::ST_RESP;
              end else if (count_r == CW'(QUEUE_DEPTH)) begin
                pend_nxt.answer = fll_pkg::ANS_FULL;
                state_nxt       = fll_pkg::ST_RESP;
              end else begin
                // wait silently at the tail
                mem_we      = 1'b1;
                mem_wclient = in_data.client_id;
                wr_off      = AW'(count_r);
                count_nxt   = count_r + CW'(1);
              end
            end
            fll_pkg::KIND_UNLOCK: begin
              if (count_r != '0 && owner_r == in_data.client_id) begin
                head_nxt             = head_inc;
                count_nxt            = count_r - CW'(1);
                serve_nxt            = (count_r != CW'(1));
                pend_nxt.answer      = fll_pkg::ANS_OK;
                pend_nxt.last_in_run = (count_r == CW'(1));
                if (count_r == CW'(1)) begin
                  rem_nxt = '0;
                end
              end
              state_nxt = fll_pkg::ST_RESP;
            end
            fll_pkg::KIND_DISC: begin
              if (count_r != '0) begin
                idx_nxt   = '0;
                rd_off    = '0;
                state_nxt = fll_pkg::ST_SCAN;
              end
            end
            fll_pkg::KIND_TICK: begin
              if (count_r != '0) begin
                if (rem_r <= LEASE_BITS'(1)) begin
                  // lease expired: drop owner
                  head_nxt  = head_inc;
                  count_nxt = count_r - CW'(1);
                  if (count_r != CW'(1)) begin
                    state_nxt = fll_pkg::ST_GRANT_RD;
                  end else begin
                    rem_nxt = '0;
                  end
                end else begin
                  rem_nxt = rem_r - LEASE_BITS'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end

      // Search for the first entry of the disconnecting client
      fll_pkg::ST_SCAN: begin
        if (mem_rclient == cli_r) begin
          if (idx_r == '0) begin
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
            if (count_r != CW'(1)) begin
              state_nxt = fll_pkg::ST_GRANT_RD;
            end else begin
              rem_nxt   = '0;
              state_nxt = fll_pkg::ST_IDLE;
            end
          end else if (idx_is_last) begin
            count_nxt = count_r - CW'(1);
            state_nxt = fll_pkg::ST_IDLE;
          end else begin
            rd_off    = idx_r + AW'(1);
            state_nxt = fll_pkg::ST_SHIFT;
          end
        end else if (idx_is_last) begin
          state_nxt = fll_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_off  = idx_r + AW'(1);
        end
      end

      // Compact: move entry idx+1 down to idx
      fll_pkg::ST_SHIFT: begin
        mem_we      = 1'b1;
        wr_off      = idx_r;
        mem_wclient = mem_rclient;
        mem_wlease  = mem_rlease;
        if (CW'(idx_r) + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = fll_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_off  = idx_r + AW'(1) + AW'(1);
        end
      end

      fll_pkg::ST_GRANT_RD: begin
        rd_off    = '0;
        state_nxt = fll_pkg::ST_GRANT;
      end

      // New head becomes owner and starts its lease
      fll_pkg::ST_GRANT: begin
        owner_nxt              = mem_rclient;
        rem_nxt                = mem_rlease;
        serve_nxt              = 1'b0;
        pend_nxt.result_kind   = fll_pkg::RK_GRANT;
        pend_nxt.target_client = mem_rclient;
        pend_nxt.answer        = fll_pkg::ANS_OK;
        pend_nxt.last_in_run   = 1'b1;
        state_nxt              = fll_pkg::ST_RESP;
      end

      fll_pkg::ST_RESP: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_nxt = serve_r ? fll_pkg::ST_GRANT_RD : fll_pkg::ST_IDLE;
        end
      end

      default: state_nxt = fll_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fll_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      rem_r   <= '0;
      serve_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      serve_r <= serve_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
    idx_r   <= idx_nxt;
    cli_r   <= cli_nxt;
    pend_r  <= pend_nxt;
  end

endmodule

### rtl/fifo_lock_with_lease_timeout_top.sv
// FIFO lock with lease timeout: lock/unlock answers, FIFO hand-over and lease expiry.
// An answer goes through ST_RESP and the output register to out_valid. A grant notice goes
// through ST_GRANT_RD, ST_GRANT, ST_RESP and the output register: after the answer on unlock,
// straight from the input on expiry, after ST_SCAN on owner disconnect. The disconnect scan and
// compaction move one entry per cycle. No new item is taken until the last is done, and result
// stalls hold ST_RESP. Reset (synchronous, rst_n low) empties the queue; no clearing.
module fifo_lock_with_lease_timeout_top #(
  parameter int QUEUE_DEPTH = fll_pkg::QUEUE_DEPTH_DEF,
  parameter int LEASE_BITS  = fll_pkg::LEASE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fll_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fll_pkg::out_item_t out_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic                         push_valid;
  logic                         push_ready;
  fll_pkg::out_item_t           push_data;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [fll_pkg::CLIENT_W-1:0] mem_wclient;
  logic [LEASE_BITS-1:0]        mem_wlease;
  logic [AW-1:0]                mem_raddr;
  logic [fll_pkg::CLIENT_W-1:0] mem_rclient;
  logic [LEASE_BITS-1:0]        mem_rlease;

  fll_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEASE_BITS  (LEASE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wclient (mem_wclient),
    .mem_wlease  (mem_wlease),
    .mem_raddr   (mem_raddr),
    .mem_rclient (mem_rclient),
    .mem_rlease  (mem_rlease)
  );

  fll_queue_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEASE_BITS  (LEASE_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wclient (mem_wclient),
    .wlease  (mem_wlease),
    .raddr   (mem_raddr),
    .rclient (mem_rclient),
    .rlease  (mem_rlease)
  );

  fll_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
